// ----- hdl/adaptive_timeslice_scheduler_unit_defines.svh -----
// assertion macros for the adaptive time-slice scheduler checker
// expects signals named clock and reset in the scope of use
`ifndef ADAPTIVE_TIMESLICE_SCHEDULER_UNIT_DEFINES_SVH
`define ADAPTIVE_TIMESLICE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ats_pkg.sv -----
// shared types, constants and the type factor table for the scheduler
// no dependencies
package ats_pkg;

   localparam int MAX_TASKS_DEFAULT = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_TYPES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_PRIOS = 2'd2;

   localparam logic OP_GRANT  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [6:0] MIN_SLICE_MS = 7'd1;
   localparam logic [6:0] MAX_SLICE_MS = 7'd100;

   typedef struct packed {
      logic       operation;
      logic [9:0] utilization;
      logic [7:0] load_count;
      logic [7:0] run_ms;
   } req_word_type;

   typedef struct packed {
      logic [2:0] task_slot;
      logic [6:0] timeslice_ms;
      logic       is_report;
   } rsp_word_type;

   // average in Q8.6 and last run time in ms
   typedef struct packed {
      logic [13:0] avg;
      logic [7:0]  last;
   } store_word_type;

   typedef struct packed {
      logic           run;
      store_word_type word;
   } entry_type;

   typedef struct packed {
      logic fact_en;
      logic mul_en;
      logic prod_en;
   } calc_ctl_type;

   // task type factor scaled by ten
   function automatic logic [3:0] kind_weight(input logic [2:0] task_type);
      logic [3:0] f;
      unique case (task_type)
         3'd0:    f = 4'd15;
         3'd1:    f = 4'd8;
         3'd2:    f = 4'd12;
         3'd3:    f = 4'd13;
         3'd4:    f = 4'd6;
         default: f = 4'd10;
      endcase
      return f;
   endfunction

endpackage

// ----- hdl/ats_state_mem.sv -----
// per-slot state store: average and last time in a synchronous memory,
// has-run valid bits in flops; depends on ats_pkg
module ats_state_mem #(
   parameter int DEPTH  = ats_pkg::MAX_TASKS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  ats_pkg::store_word_type wr_word,
   output ats_pkg::entry_type      rd_entry
);
   import ats_pkg::*;

   store_word_type    store_ff [DEPTH];
   logic [DEPTH-1:0]  run_ff;
   logic [DEPTH-1:0]  run_in;
   store_word_type    rd_word_ff;
   logic              rd_run_ff;

   always_comb begin
      run_in = run_ff;
      if (wr_en) begin
         run_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= store_ff[rd_addr];
         rd_run_ff  <= run_ff[rd_addr];
      end
   end

   assign rd_entry.run  = rd_run_ff;
   assign rd_entry.word = rd_word_ff;

endmodule

// ----- hdl/ats_avg_update.sv -----
// moving-average update for a report: 0.3*time + 0.7*avg in Q8.6, rounded
// two steps, reciprocal multiply for the divide by ten; depends on ats_pkg
module ats_avg_update (
   input  logic               clock,
   input  logic               load_en,
   input  ats_pkg::entry_type entry,
   input  logic [7:0]         run_ms,
   output logic [13:0]        new_avg
);
   import ats_pkg::*;

   logic [17:0] sum_in;
   logic [16:0] half_ff;
   logic        run_ff;
   logic [7:0]  etime_ff;
   logic [33:0] quot_full;

   // 192*t + 7*avg + 5, at most 18 bits
   assign sum_in = 18'(run_ms) * 18'd192 + 18'(entry.word.avg) * 18'd7 + 18'd5;

   always_ff @(posedge clock) begin
      if (load_en) begin
         half_ff  <= sum_in[17:1];
         run_ff   <= entry.run;
         etime_ff <= run_ms;
      end
   end

   // x/10 = (x>>1)/5, with ceil(2^19/5) exact below 2^18
   assign quot_full = 34'(half_ff) * 34'd104858;

   // first run takes the time itself
   assign new_avg = run_ff ? quot_full[32:19] : {etime_ff, 6'b000000};

endmodule

// ----- hdl/ats_slice_calc.sv -----
// grant slice arithmetic: factor stage, two multiply stages, constant divide
// and clamp at the output; depends on ats_pkg
module ats_slice_calc (
   input  logic                  clock,
   input  ats_pkg::calc_ctl_type ctl,
   input  logic [2:0]            slot_type,
   input  logic [7:0]            slot_prio,
   input  logic [9:0]            utilization,
   input  logic [7:0]            load_count,
   input  ats_pkg::entry_type    entry,
   output logic [6:0]            slice_ms
);
   import ats_pkg::*;

   logic [3:0]  t_fac;
   logic [3:0]  u_fac;
   logic [3:0]  f_fac;
   logic [3:0]  l_fac;
   logic [17:0] last_scaled;
   logic [17:0] avg_hi;
   logic [17:0] avg_lo;
   logic [7:0]  tu_in;
   logic [7:0]  fl_in;
   logic [8:0]  pr_in;
   logic [7:0]  tu_ff;
   logic [7:0]  fl_ff;
   logic [8:0]  pr_ff;
   logic [14:0] ab_in;
   logic [14:0] ab_ff;
   logic [8:0]  pr2_ff;
   logic [23:0] prod_in;
   logic [23:0] prod_ff;
   logic [26:0] quot_full;
   logic [6:0]  quot;

   assign t_fac = kind_weight(slot_type);
   assign u_fac = (utilization < 10'd800) ? 4'd12 : 4'd8;

   always_comb begin
      if (load_count > 8'd10) begin
         l_fac = 4'd8;
      end else if (load_count < 8'd3) begin
         l_fac = 4'd13;
      end else begin
         l_fac = 4'd10;
      end
   end

   // last/avg ratio against 1.2 and 0.8, avg in Q8.6
   assign last_scaled = 18'(entry.word.last) * 18'd640;
   assign avg_hi      = 18'(entry.word.avg) * 18'd12;
   assign avg_lo      = 18'(entry.word.avg) * 18'd8;

   always_comb begin
      if (!entry.run) begin
         f_fac = 4'd10;
      end else if (last_scaled > avg_hi) begin
         f_fac = 4'd13;
      end else if (last_scaled < avg_lo) begin
         f_fac = 4'd7;
      end else begin
         f_fac = 4'd10;
      end
   end

   assign tu_in = 8'(t_fac) * 8'(u_fac);
   assign fl_in = 8'(f_fac) * 8'(l_fac);
   assign pr_in = 9'd128 + 9'(slot_prio);

   always_ff @(posedge clock) begin
      if (ctl.fact_en) begin
         tu_ff <= tu_in;
         fl_ff <= fl_in;
         pr_ff <= pr_in;
      end
   end

   assign ab_in = 15'(tu_ff) * 15'(fl_ff);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         ab_ff  <= ab_in;
         pr2_ff <= pr_ff;
      end
   end

   assign prod_in = 24'(ab_ff) * 24'(pr2_ff);

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   // /256000 = (>>11) then /125 by ceil(2^20/125), exact below 21399
   assign quot_full = 27'(prod_ff[23:11]) * 27'd8389;
   assign quot      = quot_full[26:20];

   always_comb begin
      if (quot < MIN_SLICE_MS) begin
         slice_ms = MIN_SLICE_MS;
      end else if (quot > MAX_SLICE_MS) begin
         slice_ms = MAX_SLICE_MS;
      end else begin
         slice_ms = quot;
      end
   end

endmodule

// ----- hdl/adaptive_timeslice_scheduler_unit.sv -----
// grant: states fact, mul, prod and div; the result is registered on leaving div
// report: states fact and avg; the acknowledgment is registered on leaving avg
// grant time is set by the two-stage multiply chain, report time by the
// read-modify-write of the slot store (registered read, write on completion)
// one word in flight; a result waits in the output register while rsp_stall
// synchronous reset clears registers, current slot and all has-run bits
module adaptive_timeslice_scheduler_unit #(
   parameter int MAX_TASKS = ats_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ats_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ats_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_wr_en,
   input  logic [ats_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ats_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ats_pkg::*;

   localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FACT = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_PROD = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_AVG  = 6'b100000
   } state_type;

   // configuration registers
   logic [3:0]  task_count_ff;
   logic [23:0] task_types_ff;
   logic [63:0] task_prios_ff;

   // control
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] current_slot_ff, current_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   req_word_type      item_ff, item_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [6:0]        n_eff;
   logic [6:0]        count_wide;
   logic [SLOT_W-1:0] slot_eff;
   logic [SLOT_W-1:0] slot_next;
   logic [6:0]        slot_inc;
   logic              out_free;
   logic              in_fields;
   logic [2:0]        slot3;
   logic [2:0]        slot_type;
   logic [7:0]        slot_prio;

   logic              mem_rd_en;
   logic              mem_wr_en;
   entry_type         entry;
   store_word_type    wr_word;
   calc_ctl_type      calc_ctl;
   logic              avg_en;
   logic [13:0]       new_avg;
   logic [6:0]        slice_ms;

   // ---------------- configuration writes, expected only while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         task_types_ff <= '0;
         task_prios_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TASK_COUNT: task_count_ff <= csr_wdata[3:0];
            CSR_TASK_TYPES: task_types_ff <= csr_wdata[23:0];
            CSR_TASK_PRIOS: task_prios_ff <= csr_wdata;
            default: ;  // unknown index is ignored
         endcase
      end
   end

   // ---------------- slot bookkeeping
   // count above the slot store size acts as the store size
   assign count_wide = 7'(task_count_ff);
   assign n_eff      = (count_wide > 7'(MAX_TASKS)) ? 7'(MAX_TASKS) : count_wide;

   // count lowered below the current slot restarts at slot zero
   assign slot_eff = (7'(current_slot_ff) >= n_eff) ? '0 : current_slot_ff;

   // round robin advance after a report
   assign slot_inc  = 7'(slot_ff) + 7'd1;
   assign slot_next = (slot_inc == n_eff) ? '0 : SLOT_W'(slot_inc);

   // type and priority fields exist for the first eight slots only
   assign in_fields = (7'(slot_ff) < 7'd8);
   assign slot3     = 3'(slot_ff);
   assign slot_type = in_fields ? task_types_ff[3*slot3 +: 3] : 3'd0;
   assign slot_prio = in_fields ? task_prios_ff[{slot3, 3'b000} +: 8] : 8'd0;

   // output register can take a new word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign wr_word.avg  = new_avg;
   assign wr_word.last = item_ff.run_ms;

   // ---------------- sequencer
   always_comb begin
      state_in        = state_ff;
      current_slot_in = current_slot_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;
      item_in         = item_ff;
      slot_in         = slot_ff;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      calc_ctl        = '0;
      avg_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // with no slots in use a word is taken and dropped
            if (req_valid && (n_eff != 7'd0)) begin
               item_in         = req_word;
               slot_in         = slot_eff;
               current_slot_in = slot_eff;
               mem_rd_en       = 1'b1;
               state_in        = ST_FACT;
            end
         end
         ST_FACT: begin
            // slot entry is out of the store now
            if (item_ff.operation == OP_REPORT) begin
               avg_en   = 1'b1;
               state_in = ST_AVG;
            end else begin
               calc_ctl.fact_en = 1'b1;
               state_in         = ST_MUL;
            end
         end
         ST_MUL: begin
            calc_ctl.mul_en = 1'b1;
            state_in        = ST_PROD;
         end
         ST_PROD: begin
            calc_ctl.prod_en = 1'b1;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.task_slot     = slot3;
               rsp_word_in.timeslice_ms  = slice_ms;
               rsp_word_in.is_report     = 1'b0;
               state_in                  = ST_IDLE;
            end
         end
         ST_AVG: begin
            // write back and advance together with the acknowledgment
            if (out_free) begin
               mem_wr_en                 = 1'b1;
               current_slot_in           = slot_next;
               rsp_valid_in              = 1'b1;
               rsp_word_in.task_slot     = slot3;
               rsp_word_in.timeslice_ms  = '0;
               rsp_word_in.is_report     = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         current_slot_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         current_slot_ff <= current_slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slot_ff     <= slot_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------- slot store
   ats_state_mem #(
      .DEPTH  (MAX_TASKS),
      .ADDR_W (SLOT_W)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd_en),
      .rd_addr  (slot_eff),
      .wr_en    (mem_wr_en),
      .wr_addr  (slot_ff),
      .wr_word  (wr_word),
      .rd_entry (entry)
   );

   // ---------------- report path
   ats_avg_update u_avg_update (
      .clock   (clock),
      .load_en (avg_en),
      .entry   (entry),
      .run_ms  (item_ff.run_ms),
      .new_avg (new_avg)
   );

   // ---------------- grant path
   ats_slice_calc u_slice_calc (
      .clock       (clock),
      .ctl         (calc_ctl),
      .slot_type   (slot_type),
      .slot_prio   (slot_prio),
      .utilization (item_ff.utilization),
      .load_count  (item_ff.load_count),
      .entry       (entry),
      .slice_ms    (slice_ms)
   );

endmodule

// ----- hdl/ats_checker.sv -----
// port-level checks for the scheduler, bound to the top level
// depends on ats_pkg and adaptive_timeslice_scheduler_unit_defines.svh
`include "adaptive_timeslice_scheduler_unit_defines.svh"

module ats_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ats_pkg::rsp_word_type rsp_word
);
   import ats_pkg::*;

   // a grant is always within the slice limits
   `ATS_ASSERT_NOW(a_grant_range, rsp_valid && !rsp_word.is_report, (rsp_word.timeslice_ms >= MIN_SLICE_MS) && (rsp_word.timeslice_ms <= MAX_SLICE_MS), "grant slice out of range")

   // a report acknowledgment carries no slice
   `ATS_ASSERT_NOW(a_report_zero, rsp_valid && rsp_word.is_report, rsp_word.timeslice_ms == 7'd0, "report word carries a slice")

   // a new result only follows a cycle in which work was in flight
   `ATS_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall), "result without work in flight")

   // a stalled result holds
   `ATS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result changed")

endmodule

bind adaptive_timeslice_scheduler_unit ats_checker u_ats_checker (.*);

// ----- sim/tb_adaptive_timeslice_scheduler_unit.sv -----
// self-checking testbench for adaptive_timeslice_scheduler_unit: directed table then random phases
// predicts each slice and report ack in-bench and compares every returned word field by field
// depends on ats_pkg and the unit rtl
module tb_adaptive_timeslice_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ats_pkg::*;

   localparam int SLOTS = MAX_TASKS_DEFAULT;
   // register index past the last real register, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   // idle wait after a drain, room for a word that owes no result
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_WORDS = 400;
   // no bursts in the last stretch of the run
   localparam int QUIET_FROM = 340;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_WORD,
      ROW_FIXED
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      req_word_type           word;
      rsp_word_type           want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // scheduler shadow: register copies and per-slot history
   logic [3:0]       sh_count = '0;
   logic [23:0]      sh_types = '0;
   logic [63:0]      sh_prios = '0;
   logic [2:0]       sh_slot = '0;
   logic             sh_ran  [SLOTS];
   logic [13:0]      sh_avg  [SLOTS];
   logic [7:0]       sh_last [SLOTS];

   rsp_word_type     slot_results_due[$];
   plan_row_type     plan_rows[$];
   int unsigned      fault_count = 0;
   bit               quiet = 1'b0;
   bit               sender_calm = 1'b0;

   adaptive_timeslice_scheduler_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sh_ran[i]  = 1'b0;
         sh_avg[i]  = '0;
         sh_last[i] = '0;
      end
   end

   // effective slot count, anything above the slot array acts as full
   function automatic int unsigned live_slots();
      return (sh_count > SLOTS) ? SLOTS : sh_count;
   endfunction

   // advance the shadow by one accepted word; returns 1 when the unit owes a word back
   function automatic bit schedule_word(input req_word_type w, output rsp_word_type r);
      int unsigned n, s, t, u, f, l, prod, lhs, avg, et;
      r = '0;
      n = live_slots();
      if (n == 0)
         return 1'b0;
      // count was lowered under the current slot
      if (sh_slot >= n)
         sh_slot = '0;
      s = sh_slot;
      r.task_slot = sh_slot;
      if (w.operation == OP_GRANT) begin
         case (sh_types[3*s +: 3])
            3'd0:    t = 15;
            3'd1:    t = 8;
            3'd2:    t = 12;
            3'd3:    t = 13;
            3'd4:    t = 6;
            default: t = 10;
         endcase
         u = (w.utilization < 800) ? 12 : 8;
         // performance: last run against 1.2x and 0.8x of the average (avg is Q8.6)
         lhs = sh_last[s];
         lhs = lhs * 640;
         avg = sh_avg[s];
         if (!sh_ran[s])
            f = 10;
         else if (lhs > avg * 12)
            f = 13;
         else if (lhs < avg * 8)
            f = 7;
         else
            f = 10;
         if (w.load_count > 10)
            l = 8;
         else if (w.load_count < 3)
            l = 13;
         else
            l = 10;
         prod = t * u * f * l * (128 + sh_prios[8*s +: 8]) / 256000;
         if (prod < 1)
            prod = 1;
         if (prod > 100)
            prod = 100;
         r.timeslice_ms = prod[6:0];
         r.is_report = 1'b0;
      end else begin
         et = w.run_ms;
         // first report seeds the average, later ones blend 0.3 new / 0.7 old
         if (!sh_ran[s]) begin
            sh_avg[s] = 14'(et * 64);
            sh_ran[s] = 1'b1;
         end else begin
            avg = sh_avg[s];
            avg = (192 * et + 7 * avg + 5) / 10;
            sh_avg[s] = avg[13:0];
         end
         sh_last[s] = w.run_ms;
         sh_slot = 3'((s + 1) % n);
         r.timeslice_ms = '0;
         r.is_report = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic req_word_type random_word(input logic op);
      req_word_type w;
      int unsigned  near;
      w.operation = op;
      case ($urandom_range(0, 3))
         0:       w.utilization = 10'($urandom_range(0, 1023));
         1:       w.utilization = 10'($urandom_range(795, 805));
         default: w.utilization = 10'($urandom_range(0, 1000));
      endcase
      w.load_count = $urandom_range(0, 1) ? 8'($urandom_range(0, 13))
                                          : 8'($urandom_range(0, 255));
      // times close to the slot's last run keep the performance factor near neutral
      near = sh_last[sh_slot] + $urandom_range(0, 10);
      near = (near < 5) ? 0 : near - 5;
      if (near > 255)
         near = 255;
      case ($urandom_range(0, 2))
         0:       w.run_ms = 8'($urandom_range(0, 255));
         1:       w.run_ms = 8'($urandom_range(0, 31));
         default: w.run_ms = near[7:0];
      endcase
      return w;
   endfunction

   // table builders
   task automatic csr_row(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      plan_row_type p;
      p = '{kind: ROW_CSR, index: idx, data: d, word: '0, want: '0};
      plan_rows.push_back(p);
   endtask

   task automatic word_row(input logic op, input logic [9:0] ut, input logic [7:0] act,
                           input logic [7:0] et);
      plan_row_type p;
      p = '{kind: ROW_WORD, index: '0, data: '0, word: '0, want: '0};
      p.word = {op, ut, act, et};
      plan_rows.push_back(p);
   endtask

   task automatic fixed_row(input logic op, input logic [9:0] ut, input logic [7:0] act,
                            input logic [7:0] et, input logic [2:0] slot,
                            input logic [6:0] ms, input logic rep);
      plan_row_type p;
      p = '{kind: ROW_FIXED, index: '0, data: '0, word: '0, want: '0};
      p.word = {op, ut, act, et};
      p.want = {slot, ms, rep};
      plan_rows.push_back(p);
   endtask

   // present one word, hold it until taken, then log what it should produce
   task automatic send_word(input req_word_type w, input bit fixed, input rsp_word_type want);
      rsp_word_type due;
      if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (schedule_word(w, due))
         slot_results_due.push_back(fixed ? want : due);
   endtask

   // sender holds off until every owed word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (slot_results_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // idle point for register writes: drained plus room for a word that owes nothing
   task automatic settle();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      case (idx)
         CSR_TASK_COUNT: sh_count = d[3:0];
         CSR_TASK_TYPES: sh_types = d[23:0];
         CSR_TASK_PRIOS: sh_prios = d;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stall bursts and calm stretches, none near the end
   initial begin : rsp_idler
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 40) == 0) begin
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end
      end
   end

   // each word taken off the result channel must match the oldest owed word
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (slot_results_due.size() == 0) begin
            $error("word with nothing owed: slot %0d slice %0d report %0b",
                   rsp_word.task_slot, rsp_word.timeslice_ms, rsp_word.is_report);
            fault_count++;
         end else begin
            want = slot_results_due.pop_front();
            if (rsp_word.task_slot !== want.task_slot) begin
               $error("task_slot expected %0d got %0d", want.task_slot, rsp_word.task_slot);
               fault_count++;
            end
            if (rsp_word.timeslice_ms !== want.timeslice_ms) begin
               $error("timeslice_ms expected %0d got %0d",
                      want.timeslice_ms, rsp_word.timeslice_ms);
               fault_count++;
            end
            if (rsp_word.is_report !== want.is_report) begin
               $error("is_report expected %0d got %0d", want.is_report, rsp_word.is_report);
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned counted, phase, n_words;
      logic        op;
      logic [63:0] d;

      // directed table
      // reset registers: no slots, words are swallowed
      word_row(OP_GRANT, 10'd0, 8'd0, 8'd0);
      word_row(OP_REPORT, 10'd1000, 8'd255, 8'd255);
      // one slot, type training, priority zero
      csr_row(CSR_TASK_COUNT, 64'd1);
      // 1.5 * 1.2 * 1.0 * 1.3 * 0.5 -> 11 ms
      fixed_row(OP_GRANT, 10'd0, 8'd0, 8'd0, 3'd0, 7'd11, 1'b0);
      // first run seeds the average with the top time
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd255, 3'd0, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd1000, 8'd255, 8'd0);
      // zero time drags the average down, performance turns slow
      word_row(OP_REPORT, 10'd0, 8'd0, 8'd0);
      word_row(OP_GRANT, 10'd799, 8'd3, 8'd0);
      word_row(OP_GRANT, 10'd800, 8'd10, 8'd0);
      // slot s has type s, so unknown types 5..7 sit in the top slots
      csr_row(CSR_TASK_TYPES, 64'h0000_0000_00FA_C688);
      csr_row(CSR_TASK_PRIOS, 64'h00FF_807F_4001_FF00);
      // index past the register file, must change nothing
      csr_row(CSR_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
      // count above the slot array acts as eight
      csr_row(CSR_TASK_COUNT, 64'd15);
      word_row(OP_GRANT, 10'd500, 8'd11, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd1, 3'd0, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd1000, 8'd255, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd0, 3'd1, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd799, 8'd2, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd200, 3'd2, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd800, 8'd3, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd128, 3'd3, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd0, 8'd10, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd255, 3'd4, 7'd0, 1'b1);
      // count drops below the current slot (5), which wraps to slot 0
      csr_row(CSR_TASK_COUNT, 64'd2);
      word_row(OP_GRANT, 10'd300, 8'd2, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd100, 3'd0, 7'd0, 1'b1);
      // slot 1 ran with time zero: zero average, neutral factor
      word_row(OP_GRANT, 10'd300, 8'd2, 8'd0);
      fixed_row(OP_REPORT, 10'd0, 8'd0, 8'd7, 3'd1, 7'd0, 1'b1);
      word_row(OP_GRANT, 10'd999, 8'd12, 8'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan_rows[i].index, plan_rows[i].data);
         end else begin
            send_word(plan_rows[i].word, plan_rows[i].kind == ROW_FIXED, plan_rows[i].want);
         end
      end

      // random phases, each under a fresh register setting
      counted = 0;
      phase = 0;
      while (counted < RANDOM_WORDS) begin
         settle();
         if (phase == 1)
            d = 64'd0;
         else if (phase == 3)
            d = 64'd15;
         else if (phase % 5 == 2)
            d = 64'd8;
         else if ($urandom_range(0, 5) == 0)
            d = 64'($urandom_range(9, 15));
         else
            d = 64'($urandom_range(1, 8));
         write_reg(CSR_TASK_COUNT, d);
         if (phase < 4 || $urandom_range(0, 2) != 0) begin
            case (phase % 4)
               0:       d = 64'hFF_FFFF;
               1:       d = 64'd0;
               default: d = {$urandom(), $urandom()};
            endcase
            write_reg(CSR_TASK_TYPES, d);
         end
         if (phase < 4 || $urandom_range(0, 2) != 0) begin
            case ((phase + 1) % 4)
               0:       d = 64'hFFFF_FFFF_FFFF_FFFF;
               1:       d = 64'd0;
               default: d = {$urandom(), $urandom()};
            endcase
            write_reg(CSR_TASK_PRIOS, d);
         end
         if ($urandom_range(0, 6) == 0)
            write_reg(CSR_SPARE, {$urandom(), $urandom()});

         sender_calm = (phase % 3 == 2);
         n_words = (live_slots() == 0) ? 6 : $urandom_range(30, 70);
         for (int k = 0; k < n_words; k++) begin
            quiet = (counted >= QUIET_FROM);
            // mostly grant then report per slot, some out-of-pattern words
            if ($urandom_range(0, 5) == 0)
               op = 1'($urandom_range(0, 1));
            else
               op = (k % 2 == 0) ? OP_GRANT : OP_REPORT;
            if (!quiet && $urandom_range(0, 59) == 0)
               drain();
            send_word(random_word(op), 1'b0, '0);
            if (live_slots() != 0)
               counted++;
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ats_pkg.sv
hdl/ats_state_mem.sv
hdl/ats_avg_update.sv
hdl/ats_slice_calc.sv
hdl/adaptive_timeslice_scheduler_unit.sv
hdl/ats_checker.sv
sim/tb_adaptive_timeslice_scheduler_unit.sv
